// File: rtl/ihex_pkg.sv
// Package for the Intel HEX record parser: character class struct, status,
// record type and memory window codes, and the small helper functions.
// No dependencies.
`default_nettype none

package ihex_pkg;

  // Character codes seen by the parser.
  localparam logic [7:0] ChNewline = 8'd10;
  localparam logic [7:0] ChColon   = 8'h3A;

  // Shortest legal record line: colon, length, address, type, checksum.
  localparam int unsigned MinLineChars = 11;
  // Width that holds 2 * byte count + MinLineChars and any line length.
  localparam int unsigned LenW = 10;

  // Result kinds.
  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Line status codes.
  localparam logic [3:0] StOk          = 4'd0;
  localparam logic [3:0] StAfterEof    = 4'd1;
  localparam logic [3:0] StShort       = 4'd2;
  localparam logic [3:0] StLong        = 4'd3;
  localparam logic [3:0] StEven        = 4'd4;
  localparam logic [3:0] StBadChar     = 4'd5;
  localparam logic [3:0] StNoColon     = 4'd6;
  localparam logic [3:0] StChecksum    = 4'd7;
  localparam logic [3:0] StLenMismatch = 4'd8;
  localparam logic [3:0] StLenEof      = 4'd9;
  localparam logic [3:0] StLenSegAddr  = 4'd10;
  localparam logic [3:0] StLenSegStart = 4'd11;
  localparam logic [3:0] StLenLinAddr  = 4'd12;
  localparam logic [3:0] StLenLinStart = 4'd13;
  localparam logic [3:0] StBadType     = 4'd14;
  localparam logic [3:0] StUnknownMem  = 4'd15;

  // Record types.
  localparam logic [7:0] TypeData     = 8'h00;
  localparam logic [7:0] TypeEof      = 8'h01;
  localparam logic [7:0] TypeSegAddr  = 8'h02;
  localparam logic [7:0] TypeSegStart = 8'h03;
  localparam logic [7:0] TypeLinAddr  = 8'h04;
  localparam logic [7:0] TypeLinStart = 8'h05;

  // Memory windows.
  localparam logic [1:0] MemExtEeprom = 2'd0;
  localparam logic [1:0] MemFlash     = 2'd1;
  localparam logic [1:0] MemIntEeprom = 2'd2;
  localparam logic [1:0] MemUnknown   = 2'd3;

  localparam logic [15:0] ExtEepromLo = 16'h0200;
  localparam logic [15:0] ExtEepromHi = 16'h09FF;
  localparam logic [15:0] FlashALo    = 16'h2C00;
  localparam logic [15:0] FlashAHi    = 16'h37BF;
  localparam logic [15:0] FlashBLo    = 16'h3A00;
  localparam logic [15:0] FlashBHi    = 16'h3FFF;
  localparam logic [15:0] IntEepromLo = 16'hF000;
  localparam logic [15:0] IntEepromHi = 16'hF0FF;

  typedef struct packed {
    logic       is_nl;
    logic       is_ws;
    logic       is_colon;
    logic       is_hex;
    logic [3:0] nib;
  } char_class_t;

  typedef struct packed {
    logic halted;
  } core_stat_t;

  // Classifies a halved address into its memory window.
  function automatic logic [1:0] window_of(input logic [15:0] a);
    logic [1:0] m;
    m = MemUnknown;
    if (a >= ExtEepromLo && a <= ExtEepromHi) m = MemExtEeprom;
    else if (a >= FlashALo && a <= FlashAHi) m = MemFlash;
    else if (a >= FlashBLo && a <= FlashBHi) m = MemFlash;
    else if (a >= IntEepromLo && a <= IntEepromHi) m = MemIntEeprom;
    return m;
  endfunction

  // Records an error on the line. Too long wins over everything, a bad
  // character wins over the rest, and otherwise the first error stays.
  function automatic logic [3:0] mark_err(input logic [3:0] err, input logic [3:0] code);
    logic [3:0] r;
    r = err;
    if (code == StLong) r = StLong;
    else if (code == StBadChar) begin
      if (err != StLong) r = StBadChar;
    end else if (err == StOk) r = code;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ihex_char_class.sv
// Character classifier for the Intel HEX parser: newline, whitespace,
// colon and hex digit value. Depends on ihex_pkg.
`default_nettype none

module ihex_char_class (
  input  logic [7:0]           ch_i,
  output ihex_pkg::char_class_t cls_o
);

  always_comb begin
    cls_o          = '0;
    cls_o.is_nl    = (ch_i == ihex_pkg::ChNewline);
    cls_o.is_ws    = (ch_i == 8'd32) || (ch_i == 8'd9) || (ch_i == 8'd11) ||
                     (ch_i == 8'd12) || (ch_i == 8'd13);
    cls_o.is_colon = (ch_i == ihex_pkg::ChColon);
    if (ch_i >= 8'h30 && ch_i <= 8'h39) begin
      cls_o.is_hex = 1'b1;
      cls_o.nib    = 4'(ch_i - 8'h30);
    end else if (ch_i >= 8'h61 && ch_i <= 8'h66) begin
      cls_o.is_hex = 1'b1;
      cls_o.nib    = 4'(ch_i - 8'h57);
    end else if (ch_i >= 8'h41 && ch_i <= 8'h46) begin
      cls_o.is_hex = 1'b1;
      cls_o.nib    = 4'(ch_i - 8'h37);
    end
  end

endmodule

`default_nettype wire

// File: rtl/ihex_core.sv
// Record state machine and result register of the Intel HEX parser: line
// state, base address, EOF and halt flags. Depends on ihex_pkg.
`default_nettype none

module ihex_core #(
  parameter int unsigned MAX_LINE_CHARS = 521
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  item_valid_i,
  input  ihex_pkg::char_class_t cls_i,
  output logic                  res_valid_o,
  output logic                  kind_o,
  output logic [7:0]            data_byte_o,
  output logic [15:0]           record_address_o,
  output logic [6:0]            byte_index_o,
  output logic [1:0]            memory_kind_o,
  output logic [7:0]            record_type_o,
  output logic [3:0]            status_o,
  output logic                  record_accepted_o,
  output ihex_pkg::core_stat_t  stat_o
);

  localparam int unsigned CntW = $clog2(MAX_LINE_CHARS + 1);
  localparam int unsigned PosW = CntW - 1;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      csum_q, csum_d;
  logic [3:0]      hn_q, hn_d;
  logic [7:0]      bc_q, bc_d;
  logic [15:0]     off_q, off_d;
  logic [7:0]      type_q, type_d;
  logic [15:0]     word_q, word_d;
  logic [15:0]     base_q, base_d;
  logic [3:0]      err_q, err_d;
  logic            pend_q, pend_d;
  logic            eof_q, eof_d;
  logic            halted_q, halted_d;

  logic            res_valid_q, res_load;
  logic            kind_q, kind_d;
  logic [7:0]      db_q, db_d;
  logic [15:0]     addr_q, addr_d;
  logic [6:0]      idx_q, idx_d;
  logic [1:0]      mem_q, mem_d;
  logic [7:0]      rtype_q, rtype_d;
  logic [3:0]      st_q, st_d;
  logic            acc_q, acc_d;

  always_comb begin
    logic [15:0]     sum;
    logic [15:0]     half;
    logic [3:0]      err1;
    logic [7:0]      b;
    logic [PosW-1:0] p;
    logic [PosW-1:0] d;
    logic [3:0]      st;
    cnt_d = cnt_q; csum_d = csum_q; hn_d = hn_q; bc_d = bc_q; off_d = off_q;
    type_d = type_q; word_d = word_q; base_d = base_q; err_d = err_q;
    pend_d = pend_q; eof_d = eof_q; halted_d = halted_q;
    res_load = 1'b0;
    kind_d = ihex_pkg::KindData; db_d = '0; addr_d = '0; idx_d = '0;
    mem_d = ihex_pkg::MemExtEeprom; rtype_d = '0; st_d = ihex_pkg::StOk; acc_d = 1'b0;
    sum   = base_q + off_q;
    half  = {1'b0, sum[15:1]};
    err1  = err_q;
    b     = {hn_q, cls_i.nib};
    p     = cnt_q[CntW-1:1] - PosW'(1);
    d     = p - PosW'(4);
    st    = ihex_pkg::StOk;

    if (item_valid_i && !halted_q) begin
      if (cls_i.is_nl) begin
        if (cnt_q != '0 || err_q != ihex_pkg::StOk) begin
          res_load = 1'b1;
          kind_d   = ihex_pkg::KindStatus;
          rtype_d  = type_q;
          if (eof_q) st = ihex_pkg::StAfterEof;
          else if (ihex_pkg::LenW'(cnt_q) < ihex_pkg::LenW'(ihex_pkg::MinLineChars))
            st = ihex_pkg::StShort;
          else if (err_q == ihex_pkg::StLong) st = ihex_pkg::StLong;
          else if (!cnt_q[0]) st = ihex_pkg::StEven;
          else if (err_q != ihex_pkg::StOk) st = err_q;
          else if (csum_q != 8'h00) st = ihex_pkg::StChecksum;
          else if (ihex_pkg::LenW'({bc_q, 1'b0}) + ihex_pkg::LenW'(ihex_pkg::MinLineChars)
                   != ihex_pkg::LenW'(cnt_q)) st = ihex_pkg::StLenMismatch;
          else begin
            case (type_q)
              ihex_pkg::TypeData: begin
                addr_d = half;
                mem_d  = ihex_pkg::window_of(half);
                st     = (mem_d == ihex_pkg::MemUnknown) ? ihex_pkg::StUnknownMem
                                                         : ihex_pkg::StOk;
                acc_d  = (mem_d != ihex_pkg::MemUnknown);
              end
              ihex_pkg::TypeEof: begin
                st = (bc_q != 8'd0) ? ihex_pkg::StLenEof : ihex_pkg::StOk;
                if (bc_q == 8'd0) eof_d = 1'b1;
              end
              ihex_pkg::TypeSegAddr: begin
                st = (bc_q != 8'd2) ? ihex_pkg::StLenSegAddr : ihex_pkg::StOk;
                if (bc_q == 8'd2) base_d = {word_q[11:0], 4'h0};
              end
              ihex_pkg::TypeSegStart: begin
                st = (bc_q != 8'd4) ? ihex_pkg::StLenSegStart : ihex_pkg::StOk;
              end
              ihex_pkg::TypeLinAddr: begin
                st = (bc_q != 8'd2) ? ihex_pkg::StLenLinAddr : ihex_pkg::StOk;
                if (bc_q == 8'd2) base_d = '0;
              end
              ihex_pkg::TypeLinStart: begin
                st = (bc_q != 8'd4) ? ihex_pkg::StLenLinStart : ihex_pkg::StOk;
              end
              default: begin
                st = ihex_pkg::StBadType;
              end
            endcase
          end
          st_d = st;
          if (st != ihex_pkg::StOk && st != ihex_pkg::StUnknownMem) halted_d = 1'b1;
        end
        cnt_d = '0; csum_d = '0; hn_d = '0; bc_d = '0; off_d = '0;
        type_d = '0; word_d = '0; err_d = ihex_pkg::StOk; pend_d = 1'b0;
      end else if (cls_i.is_ws) begin
        if (cnt_q != '0 || err_q != ihex_pkg::StOk) pend_d = 1'b1;
      end else begin
        if (pend_q) begin
          err1   = ihex_pkg::mark_err(err_q, ihex_pkg::StBadChar);
          pend_d = 1'b0;
        end
        err_d = err1;
        if (err_q == ihex_pkg::StLong) begin
          // Rest of an overlong line is dropped.
        end else if (cnt_q >= CntW'(MAX_LINE_CHARS)) begin
          err_d = ihex_pkg::mark_err(err1, ihex_pkg::StLong);
        end else begin
          cnt_d = cnt_q + CntW'(1);
          if (cnt_q == '0) begin
            if (!cls_i.is_colon)
              err_d = ihex_pkg::mark_err(err1, cls_i.is_hex ? ihex_pkg::StNoColon
                                                            : ihex_pkg::StBadChar);
          end else if (!cls_i.is_hex) begin
            err_d = ihex_pkg::mark_err(err1, ihex_pkg::StBadChar);
          end else if (cnt_q[0]) begin
            hn_d = cls_i.nib;
          end else begin
            csum_d = csum_q + b;
            if (p == PosW'(0)) bc_d = b;
            else if (p == PosW'(1)) off_d = {b, 8'h00};
            else if (p == PosW'(2)) off_d = {off_q[15:8], b};
            else if (p == PosW'(3)) type_d = b;
            else begin
              if (d < PosW'(2)) word_d = {word_q[7:0], b};
              if (type_q == ihex_pkg::TypeData && 16'(d) < 16'(bc_q[7:1]) &&
                  err1 == ihex_pkg::StOk && !eof_q) begin
                res_load = 1'b1;
                kind_d   = ihex_pkg::KindData;
                db_d     = b;
                addr_d   = half;
                idx_d    = 7'(d);
                mem_d    = ihex_pkg::window_of(half);
                rtype_d  = type_q;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; csum_q <= '0; hn_q <= '0; bc_q <= '0; off_q <= '0;
      type_q <= '0; word_q <= '0; base_q <= '0; err_q <= ihex_pkg::StOk;
      pend_q <= 1'b0; eof_q <= 1'b0; halted_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (adv_i) begin
      cnt_q <= cnt_d; csum_q <= csum_d; hn_q <= hn_d; bc_q <= bc_d; off_q <= off_d;
      type_q <= type_d; word_q <= word_d; base_q <= base_d; err_q <= err_d;
      pend_q <= pend_d; eof_q <= eof_d; halted_q <= halted_d;
      res_valid_q <= res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && res_load) begin
      kind_q <= kind_d; db_q <= db_d; addr_q <= addr_d; idx_q <= idx_d;
      mem_q <= mem_d; rtype_q <= rtype_d; st_q <= st_d; acc_q <= acc_d;
    end
  end

  assign res_valid_o       = res_valid_q;
  assign kind_o            = kind_q;
  assign data_byte_o       = db_q;
  assign record_address_o  = addr_q;
  assign byte_index_o      = idx_q;
  assign memory_kind_o     = mem_q;
  assign record_type_o     = rtype_q;
  assign status_o          = st_q;
  assign record_accepted_o = acc_q;
  assign stat_o.halted     = halted_q;

endmodule

`default_nettype wire

// File: rtl/intel_hex_record_parser.sv
// Top level of the Intel HEX record parser: input register, character
// classifier and record core. Depends on ihex_pkg, ihex_char_class, ihex_core.
`default_nettype none

//  Channel | Handshake                 | Payload
//  --------+---------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o   | ch_i
//  out     | out_valid_o / out_stall_i | kind_o data_byte_o record_address_o
//          |                           | byte_index_o memory_kind_o record_type_o
//          |                           | status_o record_accepted_o
//
// One character is taken per clock while in_stall_o is low; its result, if any,
// passes the input register and then the result register of the record core.
// The core does the line state update for each character, with the address add
// and window compare. in_stall_o is high only while a result waits in the output
// register and the sink stalls; the whole pipe then holds. Reset clears the line
// state, base address, EOF and halt flags.

module intel_hex_record_parser #(
  parameter int unsigned MAX_LINE_CHARS = 521
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] record_address_o,
  output logic [6:0]  byte_index_o,
  output logic [1:0]  memory_kind_o,
  output logic [7:0]  record_type_o,
  output logic [3:0]  status_o,
  output logic        record_accepted_o
);

  // The pipe advances whenever the output register is free or being drained.
  logic adv;
  logic in_vld_q;
  logic [7:0] in_ch_q;
  ihex_pkg::char_class_t cls;
  ihex_pkg::core_stat_t  stat;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Input register; a character is captured on every beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      in_ch_q <= ch_i;
    end
  end

  ihex_char_class u_class (
    .ch_i  (in_ch_q),
    .cls_o (cls)
  );

  // The core updates the line state and loads the result register.
  ihex_core #(
    .MAX_LINE_CHARS (MAX_LINE_CHARS)
  ) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (adv),
    .item_valid_i      (in_vld_q),
    .cls_i             (cls),
    .res_valid_o       (out_valid_o),
    .kind_o            (kind_o),
    .data_byte_o       (data_byte_o),
    .record_address_o  (record_address_o),
    .byte_index_o      (byte_index_o),
    .memory_kind_o     (memory_kind_o),
    .record_type_o     (record_type_o),
    .status_o          (status_o),
    .record_accepted_o (record_accepted_o),
    .stat_o            (stat)
  );

  // Data bytes come only from type 00 records and carry a clean status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == ihex_pkg::KindData) |->
      (status_o == ihex_pkg::StOk && !record_accepted_o &&
       record_type_o == ihex_pkg::TypeData))
    else $error("data beat with status or nonzero record type");

  // An accepted record is an ok status in a known memory window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_accepted_o) |->
      (kind_o == ihex_pkg::KindStatus && status_o == ihex_pkg::StOk &&
       memory_kind_o != ihex_pkg::MemUnknown))
    else $error("accepted record with bad status or unknown memory");

  // Once halted and the last status has drained, no further result appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.halted && $past(stat.halted) && $past(adv)) |-> !out_valid_o)
    else $error("result produced while halted");

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for intel_hex_record_parser: streams characters of Intel HEX
// text, predicts every result beat with a behavioral parser and checks the output port.
// Depends on ihex_pkg and the RTL of intel_hex_record_parser.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default line length limit.
  localparam int MaxLineChars = 521;
  // Cycles without any beat on either channel before the run is declared hung.
  localparam int StallLimit = 4000;
  // Mismatches beyond this count are only counted.
  localparam int ReportLimit = 10;

  // Whitespace characters that the parser skips at the ends of a line.
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;

  // Ways to end the run with a halting line. Only one of them can be used per run,
  // because the block stays halted until reset and reset is applied only once.
  typedef enum int {
    FaultAfterEof, FaultShort, FaultLong, FaultEven, FaultSpace, FaultColon,
    FaultBadChar, FaultFirstChar, FaultNoColon, FaultChecksum, FaultCount,
    FaultTypeLen, FaultType
  } fault_e;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] record_address;
    logic [6:0]  byte_index;
    logic [1:0]  memory_kind;
    logic [7:0]  record_type;
    logic [3:0]  status;
    logic        record_accepted;
  } hex_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  ch = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [7:0]  data_byte;
  logic [15:0] record_address;
  logic [6:0]  byte_index;
  logic [1:0]  memory_kind;
  logic [7:0]  record_type;
  logic [3:0]  status;
  logic        record_accepted;

  intel_hex_record_parser #(
    .MAX_LINE_CHARS(MaxLineChars)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .ch_i             (ch),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .kind_o           (kind),
    .data_byte_o      (data_byte),
    .record_address_o (record_address),
    .byte_index_o     (byte_index),
    .memory_kind_o    (memory_kind),
    .record_type_o    (record_type),
    .status_o         (status),
    .record_accepted_o(record_accepted)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle rates of the two sides, in percent of cycles.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int chars_sent = 0;

  // Result beats that the parser model has produced and the block still owes.
  hex_result_t parsed_results[$];

  // Characters of the line being built by the stimulus helpers.
  logic [7:0] line_buf[$];

  // ---------------------------------------------------------------------------
  // Parser model. It mirrors the per-line state of the block and is advanced once
  // for every character beat that the block accepts.
  // ---------------------------------------------------------------------------
  logic [9:0]  line_len;        // characters counted on the line, colon included
  logic [7:0]  line_sum;        // running byte sum for the checksum test
  logic [3:0]  high_digit;      // upper nibble of the byte being decoded
  logic [7:0]  declared_count;  // byte count field of the record
  logic [15:0] load_offset;     // address field of the record
  logic [7:0]  rec_type;        // record type field
  logic [15:0] first_word;      // first two data bytes, big endian
  logic [15:0] base_addr;       // base set by segment and linear address records
  logic [3:0]  line_fault;      // strongest error seen on the line so far
  logic        space_pending;   // whitespace followed text; an error if text resumes
  logic        eof_done;        // an end-of-file record has been accepted
  logic        parser_halted;   // an error line was reported; nothing more happens

  function automatic void clear_line();
    line_len = '0;
    line_sum = '0;
    high_digit = '0;
    declared_count = '0;
    load_offset = '0;
    rec_type = '0;
    first_word = '0;
    line_fault = ihex_pkg::StOk;
    space_pending = 1'b0;
  endfunction

  function automatic void reset_parser();
    clear_line();
    base_addr = '0;
    eof_done = 1'b0;
    parser_halted = 1'b0;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChVt || c == ChFf || c == ChCr;
  endfunction

  // Returns {valid, value} of a hex digit in either case.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    return 5'd0;
  endfunction

  // Memory window of a halved record address.
  function automatic logic [1:0] mem_window(input logic [15:0] a);
    if (a >= ihex_pkg::ExtEepromLo && a <= ihex_pkg::ExtEepromHi)
      return ihex_pkg::MemExtEeprom;
    if (a >= ihex_pkg::FlashALo && a <= ihex_pkg::FlashAHi) return ihex_pkg::MemFlash;
    if (a >= ihex_pkg::FlashBLo && a <= ihex_pkg::FlashBHi) return ihex_pkg::MemFlash;
    if (a >= ihex_pkg::IntEepromLo && a <= ihex_pkg::IntEepromHi)
      return ihex_pkg::MemIntEeprom;
    return ihex_pkg::MemUnknown;
  endfunction

  // The record address is the 16-bit sum of base and offset, halved.
  function automatic logic [15:0] halved_addr();
    logic [15:0] sum;
    sum = base_addr + load_offset;
    return {1'b0, sum[15:1]};
  endfunction

  // A too-long line beats everything, a bad character beats the rest, and
  // otherwise the first error on the line is kept.
  function automatic void note_fault(input logic [3:0] code);
    if (code == ihex_pkg::StLong) line_fault = ihex_pkg::StLong;
    else if (code == ihex_pkg::StBadChar) begin
      if (line_fault != ihex_pkg::StLong) line_fault = ihex_pkg::StBadChar;
    end else if (line_fault == ihex_pkg::StOk) line_fault = code;
  endfunction

  // Newline: rate the finished line and queue its status beat.
  function automatic void close_line();
    hex_result_t r;
    logic [3:0] st;
    if (line_len == 0 && line_fault == ihex_pkg::StOk) begin
      clear_line();
      return;
    end
    r = '0;
    r.kind = ihex_pkg::KindStatus;
    r.record_type = rec_type;
    if (eof_done) st = ihex_pkg::StAfterEof;
    else if (line_len < ihex_pkg::MinLineChars) st = ihex_pkg::StShort;
    else if (line_fault == ihex_pkg::StLong) st = ihex_pkg::StLong;
    else if (!line_len[0]) st = ihex_pkg::StEven;
    else if (line_fault != ihex_pkg::StOk) st = line_fault;
    else if (line_sum != 8'd0) st = ihex_pkg::StChecksum;
    else if (2 * int'(declared_count) + int'(ihex_pkg::MinLineChars) != int'(line_len))
      st = ihex_pkg::StLenMismatch;
    else begin
      case (rec_type)
        ihex_pkg::TypeData: begin
          r.record_address = halved_addr();
          r.memory_kind = mem_window(r.record_address);
          st = (r.memory_kind == ihex_pkg::MemUnknown) ? ihex_pkg::StUnknownMem
                                                       : ihex_pkg::StOk;
          r.record_accepted = (st == ihex_pkg::StOk);
        end
        ihex_pkg::TypeEof: begin
          st = (declared_count != 0) ? ihex_pkg::StLenEof : ihex_pkg::StOk;
          if (st == ihex_pkg::StOk) eof_done = 1'b1;
        end
        ihex_pkg::TypeSegAddr: begin
          st = (declared_count != 2) ? ihex_pkg::StLenSegAddr : ihex_pkg::StOk;
          if (st == ihex_pkg::StOk) base_addr = {first_word[11:0], 4'h0};
        end
        ihex_pkg::TypeSegStart:
          st = (declared_count != 4) ? ihex_pkg::StLenSegStart : ihex_pkg::StOk;
        ihex_pkg::TypeLinAddr: begin
          st = (declared_count != 2) ? ihex_pkg::StLenLinAddr : ihex_pkg::StOk;
          if (st == ihex_pkg::StOk) base_addr = '0;
        end
        ihex_pkg::TypeLinStart:
          st = (declared_count != 4) ? ihex_pkg::StLenLinStart : ihex_pkg::StOk;
        default: st = ihex_pkg::StBadType;
      endcase
    end
    // Unknown memory only drops the record; every other error stops the block.
    if (st != ihex_pkg::StOk && st != ihex_pkg::StUnknownMem) parser_halted = 1'b1;
    r.status = st;
    parsed_results.insert(parsed_results.size(), r);
    clear_line();
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    logic [4:0] digit;
    logic [9:0] col;
    logic [9:0] pos;
    logic [9:0] idx;
    logic [7:0] b;
    hex_result_t r;
    if (parser_halted) return;
    if (c == ihex_pkg::ChNewline) begin
      close_line();
      return;
    end
    // Whitespace is skipped, but text after it on a line already begun is an error.
    if (is_space(c)) begin
      if (line_len != 0 || line_fault != ihex_pkg::StOk) space_pending = 1'b1;
      return;
    end
    if (space_pending) begin
      note_fault(ihex_pkg::StBadChar);
      space_pending = 1'b0;
    end
    if (line_fault == ihex_pkg::StLong) return;
    if (line_len >= MaxLineChars) begin
      note_fault(ihex_pkg::StLong);
      return;
    end
    col = line_len;
    line_len = line_len + 10'd1;
    digit = hex_digit(c);
    if (col == 0) begin
      if (c != ihex_pkg::ChColon)
        note_fault(digit[4] ? ihex_pkg::StNoColon : ihex_pkg::StBadChar);
      return;
    end
    if (!digit[4]) begin
      note_fault(ihex_pkg::StBadChar);
      return;
    end
    if (col[0]) begin
      high_digit = digit[3:0];
      return;
    end
    b = {high_digit, digit[3:0]};
    line_sum = line_sum + b;
    pos = (col >> 1) - 10'd1;
    if (pos == 0) declared_count = b;
    else if (pos == 1) load_offset = {b, 8'h00};
    else if (pos == 2) load_offset[7:0] = b;
    else if (pos == 3) rec_type = b;
    else begin
      idx = pos - 10'd4;
      if (idx < 2) first_word = {first_word[7:0], b};
      // The first half of the declared data bytes goes out as soon as it arrives.
      if (rec_type == ihex_pkg::TypeData && idx < (declared_count >> 1) &&
          line_fault == ihex_pkg::StOk && !eof_done) begin
        r = '0;
        r.kind = ihex_pkg::KindData;
        r.data_byte = b;
        r.record_address = halved_addr();
        r.byte_index = idx[6:0];
        r.memory_kind = mem_window(r.record_address);
        r.record_type = rec_type;
        r.status = ihex_pkg::StOk;
        parsed_results.insert(parsed_results.size(), r);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall, and every accepted beat checked against the
  // oldest prediction. Values are sampled as they stood before the clock edge.
  // ---------------------------------------------------------------------------
  function automatic string describe(input hex_result_t r);
    return $sformatf("kind=%0d byte=%h addr=%h index=%0d mem=%0d type=%h status=%0d kept=%0d",
                     r.kind, r.data_byte, r.record_address, r.byte_index, r.memory_kind,
                     r.record_type, r.status, r.record_accepted);
  endfunction

  always @(posedge clk) begin : check_results
    hex_result_t got;
    hex_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{kind, data_byte, record_address, byte_index, memory_kind, record_type,
              status, record_accepted};
      if (parsed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%t: result beat with nothing expected: %s", $realtime, describe(got));
      end else begin
        want = parsed_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("%t: result mismatch\n  expected %s\n  actual   %s", $realtime,
                     describe(want), describe(got));
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < rx_idle_pct);
  end

  // Hang detection: the run ends if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Sends one character beat, with random idle cycles ahead of it. Valid stays
  // high after the beat; the next call either lowers it or presents new data.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    do @(posedge clk); while (in_stall);
    parse_char(c);
    chars_sent++;
  endtask

  // Holds the input idle until every predicted result has been seen.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (parsed_results.size() != 0);
  endtask

  function automatic logic [7:0] space_char();
    case ($urandom_range(4))
      0: return ChSpace;
      1: return ChTab;
      2: return ChVt;
      3: return ChFf;
      default: return ChCr;
    endcase
  endfunction

  // Hex digit in a random letter case.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h57 : 8'h37) + 8'(n);
  endfunction

  // Any character that is not a hex digit, whitespace, newline or, unless allowed, a colon.
  function automatic logic [7:0] bad_char(input logic allow_colon);
    logic [7:0] c;
    logic [4:0] dg;
    do begin
      c = 8'($urandom_range(255));
      dg = hex_digit(c);
    end while (dg[4] || is_space(c) || c == ihex_pkg::ChNewline ||
               (!allow_colon && c == ihex_pkg::ChColon));
    return c;
  endfunction

  function automatic byte_q_t random_body(input int n);
    byte_q_t q;
    repeat (n) q.insert(q.size(), 8'($urandom));
    return q;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    line_buf.insert(line_buf.size(), hex_char(b[7:4]));
    line_buf.insert(line_buf.size(), hex_char(b[3:0]));
  endfunction

  // Builds a record line into line_buf. A nonzero skew spoils the checksum.
  function automatic void build_record(input logic [7:0] count, input logic [15:0] offs,
                                       input logic [7:0] rtype, input byte_q_t body,
                                       input logic [7:0] skew);
    logic [7:0] sum;
    sum = count + offs[15:8] + offs[7:0] + rtype;
    line_buf.delete();
    line_buf.insert(line_buf.size(), ihex_pkg::ChColon);
    put_byte(count);
    put_byte(offs[15:8]);
    put_byte(offs[7:0]);
    put_byte(rtype);
    foreach (body[i]) begin
      put_byte(body[i]);
      sum = sum + body[i];
    end
    put_byte(8'(8'd0 - sum) + skew);
  endfunction

  // Sends line_buf and a newline, optionally wrapped in whitespace.
  task automatic send_line(input logic pad);
    if (pad) repeat ($urandom_range(2)) send_char(space_char());
    foreach (line_buf[i]) send_char(line_buf[i]);
    if (pad) repeat ($urandom_range(2)) send_char(space_char());
    send_char(ihex_pkg::ChNewline);
  endtask

  task automatic send_record(input logic [15:0] offs, input logic [7:0] rtype,
                             input byte_q_t body, input logic pad);
    build_record(8'(body.size()), offs, rtype, body, 8'd0);
    send_line(pad);
  endtask

  // Offset that lands the halved address in, or just beside, a memory window, or anywhere.
  // The halved address never exceeds 0x7FFF, so the internal eeprom window
  // cannot be reached and is not aimed at.
  function automatic logic [15:0] aim_offset();
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] h;
    case ($urandom_range(3))
      0: begin lo = ihex_pkg::ExtEepromLo; hi = ihex_pkg::ExtEepromHi; end
      1: begin lo = ihex_pkg::FlashALo; hi = ihex_pkg::FlashAHi; end
      2: begin lo = ihex_pkg::FlashBLo; hi = ihex_pkg::FlashBHi; end
      default: begin lo = 16'h0000; hi = 16'h7FFF; end
    endcase
    case ($urandom_range(5))
      0: h = lo;
      1: h = hi;
      2: h = lo - 16'd1;
      3: h = hi + 16'd1;
      default: h = 16'($urandom_range(hi, lo));
    endcase
    return {h[14:0], 1'($urandom_range(1))} - base_addr;
  endfunction

  // One well-formed line: mostly data records, some address and start records,
  // and empty or blank lines. Most records are short, a few run up to the full length.
  task automatic send_random_line();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 68) begin
      n = ($urandom_range(49) == 0) ? $urandom_range(255) : $urandom_range(16);
      send_record(aim_offset(), ihex_pkg::TypeData, random_body(n), 1'($urandom_range(1)));
    end else if (pick < 76) begin
      send_record(16'($urandom), ihex_pkg::TypeSegAddr, random_body(2),
                  1'($urandom_range(1)));
    end else if (pick < 81) begin
      send_record(16'($urandom), ihex_pkg::TypeLinAddr, random_body(2),
                  1'($urandom_range(1)));
    end else if (pick < 84) begin
      send_record(16'($urandom), ihex_pkg::TypeSegStart, random_body(4),
                  1'($urandom_range(1)));
    end else if (pick < 87) begin
      send_record(16'($urandom), ihex_pkg::TypeLinStart, random_body(4),
                  1'($urandom_range(1)));
    end else begin
      // Empty or blank line: no result is due.
      line_buf.delete();
      send_line(pick >= 94);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Window edges, every record type but end of file, empty and blank lines, odd byte counts,
  // the base wrapping past 16 bits, and a record of the largest length.
  task automatic test_directed();
    byte_q_t body;
    tx_idle_pct = 31;
    rx_idle_pct = 61;
    send_char(ihex_pkg::ChNewline);
    send_char(ChTab);
    send_char(ChSpace);
    send_char(ChCr);
    send_char(ihex_pkg::ChNewline);
    body.insert(body.size(), 8'h00);
    body.insert(body.size(), 8'hFF);
    body.insert(body.size(), 8'hA5);
    body.insert(body.size(), 8'h5A);
    send_record(16'h0400, ihex_pkg::TypeData, body, 1'b1);            // first external word
    send_record(16'h03FE, ihex_pkg::TypeData, random_body(2), 1'b0);  // just below it
    send_record(16'h13FF, ihex_pkg::TypeData, random_body(3), 1'b0);  // last external word
    send_record(16'h1400, ihex_pkg::TypeData, random_body(2), 1'b0);  // just past it
    send_record(16'h5800, ihex_pkg::TypeData, random_body(6), 1'b0);  // first flash word
    send_record(16'h6F7E, ihex_pkg::TypeData, random_body(1), 1'b0);  // end of lower flash
    send_record(16'h6F80, ihex_pkg::TypeData, random_body(2), 1'b0);  // hole in flash
    send_record(16'h7400, ihex_pkg::TypeData, random_body(0), 1'b0);  // upper flash, no data
    send_record(16'h7FFF, ihex_pkg::TypeData, random_body(2), 1'b0);  // last flash word
    send_record(16'h0000, ihex_pkg::TypeSegStart, random_body(4), 1'b1);
    send_record(16'h0000, ihex_pkg::TypeLinStart, random_body(4), 1'b1);
    body.delete();
    body.insert(body.size(), 8'hFF);
    body.insert(body.size(), 8'hFF);
    send_record(16'h0000, ihex_pkg::TypeSegAddr, body, 1'b0);           // base 0xFFF0
    send_record(16'h0420, ihex_pkg::TypeData, random_body(4), 1'b0);    // sum wraps to 0x0410
    send_record(16'h0000, ihex_pkg::TypeLinAddr, random_body(2), 1'b0); // base back to zero
    send_record(16'h5800, ihex_pkg::TypeData, random_body(255), 1'b0);  // longest legal line
    wait_drained();
  endtask

  // Well-formed random text under one setting of the idle rates. Halfway the
  // input holds until the output has caught up completely.
  task automatic test_random_stream(input int n_chars, input int tx_pct, input int rx_pct);
    int start;
    logic paused;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = chars_sent;
    paused = 1'b0;
    while (chars_sent - start < n_chars) begin
      if (!paused && chars_sent - start > n_chars / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      send_random_line();
    end
  endtask

  // One line that stops the block, chosen at random, after which more text and
  // random bytes of every value must be swallowed without any result.
  task automatic test_halting_fault();
    fault_e fault;
    byte_q_t body;
    byte_q_t empty_body;
    logic [7:0] rtype;
    int n;
    int need;
    fault = fault_e'($urandom_range(FaultType));
    n = $urandom_range(12, 1);
    body = random_body(n);
    build_record(8'(n), aim_offset(), ihex_pkg::TypeData, body, 8'd0);
    case (fault)
      FaultAfterEof: begin
        // A valid end-of-file record; any nonempty line after it is an error.
        build_record(8'd0, 16'h0000, ihex_pkg::TypeEof, empty_body, 8'd0);
        send_line(1'b1);
        build_record(8'(n), aim_offset(), ihex_pkg::TypeData, body, 8'd0);
      end
      FaultShort: line_buf = line_buf[0:$urandom_range(9)];
      FaultLong: begin
        build_record(8'd255, aim_offset(), ihex_pkg::TypeData, random_body(255), 8'd0);
        repeat ($urandom_range(20, 1))
          line_buf.insert(line_buf.size(), hex_char(4'($urandom)));
      end
      FaultEven: line_buf.delete($urandom_range(line_buf.size() - 1, 1));
      FaultSpace: line_buf.insert($urandom_range(line_buf.size() - 1, 1), space_char());
      FaultColon: line_buf[$urandom_range(line_buf.size() - 1, 1)] = ihex_pkg::ChColon;
      FaultBadChar: line_buf[$urandom_range(line_buf.size() - 1, 1)] = bad_char(1'b1);
      FaultFirstChar: line_buf[0] = bad_char(1'b0);
      FaultNoColon: line_buf[0] = hex_char(4'($urandom));
      FaultChecksum:
        build_record(8'(n), aim_offset(), ihex_pkg::TypeData, body,
                     8'($urandom_range(255, 1)));
      FaultCount:
        build_record(8'(n + $urandom_range(255, 1)), aim_offset(), ihex_pkg::TypeData,
                     body, 8'd0);
      FaultTypeLen: begin
        rtype = 8'($urandom_range(ihex_pkg::TypeLinStart, ihex_pkg::TypeEof));
        need = (rtype == ihex_pkg::TypeEof) ? 0 :
               (rtype == ihex_pkg::TypeSegAddr || rtype == ihex_pkg::TypeLinAddr) ? 2 : 4;
        do n = $urandom_range(6); while (n == need);
        build_record(8'(n), 16'($urandom), rtype, random_body(n), 8'd0);
      end
      default: begin
        rtype = 8'($urandom_range(255, 6));
        build_record(8'(n), 16'($urandom), rtype, body, 8'd0);
      end
    endcase
    send_line(1'($urandom_range(1)));
    repeat (4) send_random_line();
    repeat (96) send_char(8'($urandom));
    send_char(ihex_pkg::ChNewline);
  endtask

  initial begin
    reset_parser();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_stream(200, 31, 61);
    test_random_stream(200, 61, 31);
    test_random_stream(200, 0, 0);
    test_halting_fault();
    wait_drained();
    // Let anything the block should not have produced show up.
    repeat (8) @(posedge clk);
    mismatches += parsed_results.size();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ihex_pkg.sv
rtl/ihex_char_class.sv
rtl/ihex_core.sv
rtl/intel_hex_record_parser.sv
dv/tb.sv
